### design/usp_pkg.sv
// Shared constants, types and state codes for the unit-weight shortest path block.
package usp_pkg;

  localparam int MAX_NODES = 64;
  localparam int NODE_W    = 7;
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int HOP_W     = 6;
  localparam int DIST_W    = HOP_W + 1;

  // bit HOP_W set marks a node that has not been reached
  localparam logic [DIST_W-1:0] UNREACHED = DIST_W'(1) << HOP_W;

  localparam logic [1:0] FUNC_ADD     = 2'd0;
  localparam logic [1:0] FUNC_COMPUTE = 2'd1;
  localparam logic [1:0] FUNC_CLEAR   = 2'd2;

  localparam logic REG_NODE_COUNT = 1'b0;
  localparam logic REG_SOURCE     = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_SCAN,
    ST_SCAN_END,
    ST_RELAX,
    ST_RELAX_END,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_HOLD
  } usp_state_t;

  // write command to the adjacency store
  typedef struct packed {
    logic             set;
    logic             clear;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } adj_cmd_t;

endpackage

### design/usp_adj_mem.sv
// Adjacency store: one row per node, lower triangle used, per-row valid bits for fast clear.
module usp_adj_mem
  import usp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  adj_cmd_t             cmd,
  input  logic [IDX_W-1:0]     rd_row,
  output logic [MAX_NODES-1:0] rd_bits
);

  logic [MAX_NODES-1:0] mem [MAX_NODES];
  logic [MAX_NODES-1:0] row_valid;
  logic [MAX_NODES-1:0] rd_data;
  logic                 rd_ok;

  // a row that is not valid reads as empty
  assign rd_bits = rd_ok ? rd_data : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (cmd.clear) begin
      row_valid <= '0;
    end else if (cmd.set) begin
      row_valid[cmd.row] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set && !cmd.clear) begin
      if (row_valid[cmd.row]) begin
        mem[cmd.row][cmd.col] <= 1'b1;
      end else begin
        mem[cmd.row] <= MAX_NODES'(1) << cmd.col;
      end
    end
    rd_data <= mem[rd_row];
    rd_ok   <= row_valid[rd_row];
  end

endmodule

### design/unit_weight_shortest_path.sv
// Top level of the unit-weight shortest path block: sequencer, distance memory, ports.
//
// Usage: words enter on the s_ group. func 0 adds the undirected edge {node_a, node_b},
// func 2 clears the graph, func 1 runs a hop-count shortest path search from
// source_node over nodes 1..n (node_count saturated into 2..64) and emits one result
// word per node on the m_ group, in node order, with m_tlast on the final node.
// Self-loops, ends that are zero or above n, and func 3 are dropped without a result.
// Configuration: cfg_wr_en writes cfg_data to register cfg_index (0 node_count,
// 1 source_node) in the same edge; write only while no search is running.
// Operation: add and clear return no result. A search first initializes the distance
// memory, then runs up to n rounds of a minimum scan and a relaxation pass and a
// closing scan that finds no open node, one read of the distance memory per cycle through a
// single comparator that serves both the minimum scan and the relaxation test, then
// emits the result words through the output register. s_tready stays low for the
// whole search.
// A stalled receiver holds the current result word in the output register and the
// search waits. Reset (rst, synchronous) empties the graph by clearing the row valid
// bits, sets node_count to 64 and source_node to 1.
module unit_weight_shortest_path
  import usp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // func[1:0], node_a[8:2], node_b[15:9]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // node_index[6:0], distance[12:7], zero fill[15:13]
  output logic        m_tuser,   // unreachable
  output logic        m_tlast,   // last_result
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);

  usp_state_t state, state_next;

  logic [NODE_W-1:0] node_count;
  logic [NODE_W-1:0] source_node;

  // input word fields
  logic [1:0]        in_func;
  logic [NODE_W-1:0] in_a;
  logic [NODE_W-1:0] in_b;
  assign in_func = s_tdata[1:0];
  assign in_a    = s_tdata[8:2];
  assign in_b    = s_tdata[15:9];

  logic              in_accept;
  logic              out_accept;
  logic [NODE_W-1:0] n_act;
  logic [IDX_W-1:0]  n_m1;
  logic              src_ok;
  logic              edge_ok;
  logic [NODE_W-1:0] edge_hi;
  logic [NODE_W-1:0] edge_lo;
  adj_cmd_t          adj_cmd;

  // sequencer datapath
  logic [IDX_W-1:0]     ptr;
  logic [MAX_NODES-1:0] visited;
  logic [DIST_W-1:0]    best;
  logic [DIST_W-1:0]    best_p1;
  logic [IDX_W-1:0]     pick;
  logic [IDX_W-1:0]     pick_next;
  logic                 found;
  logic                 found_next;
  logic                 prev_scan;
  logic                 prev_relax;
  logic [IDX_W-1:0]     prev_idx;
  logic [IDX_W-1:0]     prev_col;
  logic                 ptr_last;

  // distance memory
  logic [DIST_W-1:0] dist_mem [MAX_NODES];
  logic              dist_we;
  logic [IDX_W-1:0]  dist_waddr;
  logic [DIST_W-1:0] dist_wdata;
  logic [IDX_W-1:0]  dist_raddr;
  logic [DIST_W-1:0] dist_rdata;

  // adjacency read
  logic [IDX_W-1:0]     adj_row;
  logic [IDX_W-1:0]     adj_col;
  logic [MAX_NODES-1:0] adj_bits;

  // shared comparator
  logic [DIST_W-1:0] cmp_a;
  logic [DIST_W-1:0] cmp_b;
  logic              cmp_lt;
  logic              scan_hit;
  logic              relax_hit;

  // output register
  logic              out_valid;
  logic [NODE_W-1:0] out_node;
  logic [HOP_W-1:0]  out_dist;
  logic              out_unr;
  logic              out_last;

  assign s_tready   = (state == ST_IDLE);
  assign in_accept  = s_tvalid && s_tready;
  assign out_accept = out_valid && m_tready;

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_dist, out_node};
  assign m_tuser  = out_unr;
  assign m_tlast  = out_last;

  // saturate node count into 2..MAX_NODES
  always_comb begin
    priority if (node_count < NODE_W'(2)) begin
      n_act = NODE_W'(2);
    end else if (node_count > NODE_W'(MAX_NODES)) begin
      n_act = NODE_W'(MAX_NODES);
    end else begin
      n_act = node_count;
    end
  end

  assign n_m1     = IDX_W'(n_act - NODE_W'(1));
  assign ptr_last = (ptr == n_m1);
  assign src_ok   = (source_node != '0) && (source_node <= n_act);

  assign edge_ok = (in_a != in_b) && (in_a != '0) && (in_b != '0) &&
                   (in_a <= n_act) && (in_b <= n_act);
  assign edge_hi = (in_a > in_b) ? in_a : in_b;
  assign edge_lo = (in_a > in_b) ? in_b : in_a;

  // store the edge in row of the higher end, column of the lower end
  always_comb begin
    adj_cmd.set   = in_accept && (in_func == FUNC_ADD) && edge_ok;
    adj_cmd.clear = in_accept && (in_func == FUNC_CLEAR);
    adj_cmd.row   = IDX_W'(edge_hi - NODE_W'(1));
    adj_cmd.col   = IDX_W'(edge_lo - NODE_W'(1));
  end

  // neighbor test for pick and ptr lives in row max, column min
  assign adj_row = (pick > ptr) ? pick : ptr;
  assign adj_col = (pick > ptr) ? ptr : pick;

  usp_adj_mem u_adj (
    .clk     (clk),
    .rst     (rst),
    .cmd     (adj_cmd),
    .rd_row  (adj_row),
    .rd_bits (adj_bits)
  );

  assign best_p1 = best + DIST_W'(1);

  // one comparator: scan asks rdata < best, relax asks best+1 < rdata
  assign cmp_a  = prev_relax ? best_p1 : dist_rdata;
  assign cmp_b  = prev_relax ? dist_rdata : best;
  assign cmp_lt = (cmp_a < cmp_b);

  assign scan_hit  = prev_scan && !visited[prev_idx] && cmp_lt;
  assign relax_hit = prev_relax && !visited[prev_idx] && adj_bits[prev_col] && cmp_lt;

  assign found_next = found || scan_hit;
  assign pick_next  = scan_hit ? prev_idx : pick;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept && (in_func == FUNC_COMPUTE)) state_next = ST_INIT;
      end
      ST_INIT: begin
        if (ptr_last) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (ptr_last) state_next = ST_SCAN_END;
      end
      ST_SCAN_END: begin
        state_next = found_next ? ST_RELAX : ST_EMIT_RD;
      end
      ST_RELAX: begin
        if (ptr_last) state_next = ST_RELAX_END;
      end
      ST_RELAX_END: begin
        state_next = ST_SCAN;
      end
      ST_EMIT_RD: begin
        state_next = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        state_next = ST_EMIT_HOLD;
      end
      ST_EMIT_HOLD: begin
        if (out_accept) state_next = out_last ? ST_IDLE : ST_EMIT_RD;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // memory control per state
  always_comb begin
    dist_we    = relax_hit;
    dist_waddr = prev_idx;
    dist_wdata = best_p1;
    dist_raddr = ptr;
    unique case (state)
      ST_INIT: begin
        dist_we    = 1'b1;
        dist_waddr = ptr;
        dist_wdata = (src_ok && (ptr == IDX_W'(source_node - NODE_W'(1)))) ?
                     '0 : UNREACHED;
      end
      ST_IDLE, ST_SCAN, ST_SCAN_END, ST_RELAX, ST_RELAX_END,
      ST_EMIT_RD, ST_EMIT_LD, ST_EMIT_HOLD: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (dist_we) dist_mem[dist_waddr] <= dist_wdata;
    dist_rdata <= dist_mem[dist_raddr];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count  <= NODE_W'(MAX_NODES);
      source_node <= NODE_W'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_NODE_COUNT: node_count  <= cfg_data;
        REG_SOURCE:     source_node <= cfg_data;
        default:        node_count  <= node_count;
      endcase
    end
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      visited    <= '0;
      prev_scan  <= 1'b0;
      prev_relax <= 1'b0;
      out_valid  <= 1'b0;
      found      <= 1'b0;
    end else begin
      state      <= state_next;
      prev_scan  <= (state == ST_SCAN);
      prev_relax <= (state == ST_RELAX);

      if (in_accept && (in_func == FUNC_COMPUTE)) visited <= '0;

      // start a fresh minimum scan
      if (state_next == ST_SCAN && state != ST_SCAN) begin
        found <= 1'b0;
      end else if (scan_hit) begin
        found <= 1'b1;
      end

      // mark the chosen node before relaxing its neighbors
      if (state == ST_SCAN_END && found_next) visited[pick_next] <= 1'b1;

      if (state == ST_EMIT_LD) begin
        out_valid <= 1'b1;
      end else if (out_accept) begin
        out_valid <= 1'b0;
      end
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    prev_idx <= ptr;
    prev_col <= adj_col;

    unique case (state)
      ST_INIT, ST_SCAN, ST_RELAX: begin
        ptr <= ptr_last ? '0 : ptr + IDX_W'(1);
      end
      ST_EMIT_HOLD: begin
        if (out_accept) ptr <= ptr + IDX_W'(1);
      end
      ST_IDLE, ST_SCAN_END, ST_RELAX_END: begin
        ptr <= '0;
      end
      ST_EMIT_RD, ST_EMIT_LD: begin
        ptr <= ptr;
      end
      default: begin
        ptr <= '0;
      end
    endcase

    if (state_next == ST_SCAN && state != ST_SCAN) begin
      best <= UNREACHED;
    end else if (scan_hit) begin
      best <= dist_rdata;
      pick <= prev_idx;
    end

    if (state == ST_EMIT_LD) begin
      out_node <= NODE_W'(ptr) + NODE_W'(1);
      out_unr  <= dist_rdata[HOP_W];
      out_dist <= dist_rdata[HOP_W] ? '0 : dist_rdata[HOP_W-1:0];
      out_last <= ptr_last;
    end
  end

endmodule

### tb/tb.sv
// Self-checking testbench for unit_weight_shortest_path: directed plan, a Hamiltonian path, then random graphs.
module tb;
  import usp_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 3;
  // Add and clear words leave no result behind, so let the sequencer drop back
  // to idle before touching a register.
  localparam int SETTLE_CYCLES  = 8;
  localparam int END_CYCLES     = 40;
  localparam int MAX_REPORTS    = 10;
  localparam int RANDOM_WORDS   = 200;
  localparam int MAX_WIDE       = 3;
  // Slowest legal run: every one of a few hundred words a search over 64 nodes,
  // every result word held off by the slowest receiver pattern.
  // Take that several times over.
  localparam int TIMEOUT_CYCLES = 12_000_000;

  // function code with no meaning; the block drops it
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  // What a row of the directed plan does.
  typedef enum logic [1:0] {
    ROW_WORD,
    ROW_SET_COUNT,
    ROW_SET_SOURCE
  } row_kind_t;

  // Where a search word's expectation comes from: the predictor, or a pattern
  // that is obvious from the graph and the registers alone.
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_SOURCE_ONLY,   // the source at zero hops, every other node unreachable
    CHK_NONE_REACHED,  // source outside 1..n: every node unreachable
    CHK_PAIR           // two nodes joined: source at zero, the other at one
  } check_t;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_EVERY_FOURTH,
    RDY_MOSTLY
  } ready_mode_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [6:0] value;
    logic [1:0] func;
    logic [6:0] a;
    logic [6:0] b;
    check_t     chk;
  } step_t;

  typedef struct packed {
    logic [6:0] node;
    logic [5:0] hops;
    logic       unreach;
    logic       last;
  } hop_word_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // func[1:0], node_a[8:2], node_b[15:9]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;   // node_index[6:0], distance[12:7], zero fill[15:13]
  logic        m_tuser;   // unreachable
  logic        m_tlast;   // last_result
  logic        cfg_wr_en;
  logic        cfg_index;
  logic [6:0]  cfg_data;

  unit_weight_shortest_path dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Shadow of the block: adjacency, both registers as last written (raw 7 bits).
  bit         linked [1:MAX_NODES][1:MAX_NODES];
  logic [6:0] count_reg = 7'(MAX_NODES);
  logic [6:0] src_reg   = 7'd1;

  // Result words still owed by the block, oldest first.
  hop_word_t  expected_hops [$];
  int         mismatches  = 0;
  int         useful_words = 0;
  int         burst_left  = 0;

  // Node count register saturates into 2..MAX_NODES.
  function automatic int active_count(logic [6:0] raw);
    if (raw < 2) return 2;
    if (raw > MAX_NODES) return MAX_NODES;
    return int'(raw);
  endfunction

  // Apply one accepted input word to the shadow graph and queue any result
  // words it owes. Return 1 when the word did anything at all.
  function automatic bit predict_word(logic [1:0] func, logic [6:0] a, logic [6:0] b,
                                      check_t chk);
    int         n, x, y, pick, sweep;
    logic [6:0] best;
    logic [6:0] hop [0:MAX_NODES];
    bit         seen [0:MAX_NODES];
    hop_word_t  w;
    n = active_count(count_reg);
    case (func)
      FUNC_ADD: begin
        // drop self-loops and ends outside 1..n
        if (a == b || a < 1 || b < 1 || a > n || b > n) return 1'b0;
        linked[a][b] = 1'b1;
        linked[b][a] = 1'b1;
        return 1'b1;
      end
      FUNC_CLEAR: begin
        for (x = 1; x <= MAX_NODES; x++)
          for (y = 1; y <= MAX_NODES; y++)
            linked[x][y] = 1'b0;
        return 1'b1;
      end
      FUNC_COMPUTE: begin
        if (chk == CHK_MODEL) begin
          for (x = 0; x <= MAX_NODES; x++) begin
            hop[x]  = UNREACHED;
            seen[x] = 1'b0;
          end
          if (src_reg >= 1 && src_reg <= n) hop[src_reg] = '0;
          // Each sweep settles the nearest open node, lowest index on a tie,
          // then pulls its open neighbours down to one hop further.
          for (sweep = 0; sweep < n; sweep++) begin
            pick = 0;
            best = UNREACHED;
            for (x = 1; x <= n; x++) begin
              if (!seen[x] && hop[x] < best) begin
                best = hop[x];
                pick = x;
              end
            end
            if (pick == 0) break;
            seen[pick] = 1'b1;
            for (y = 1; y <= n; y++) begin
              if (y != pick && !seen[y] && linked[pick][y] && hop[y] > best + 7'd1)
                hop[y] = best + 7'd1;
            end
          end
        end
        for (x = 1; x <= n; x++) begin
          w.node = 7'(x);
          w.last = (x == n);
          case (chk)
            CHK_SOURCE_ONLY: begin
              w.unreach = (x != src_reg);
              w.hops    = '0;
            end
            CHK_NONE_REACHED: begin
              w.unreach = 1'b1;
              w.hops    = '0;
            end
            CHK_PAIR: begin
              w.unreach = 1'b0;
              w.hops    = (x == src_reg) ? 6'd0 : 6'd1;
            end
            default: begin
              // an unreached node reports zero hops
              w.unreach = hop[x][6];
              w.hops    = hop[x][6] ? 6'd0 : hop[x][5:0];
            end
          endcase
          expected_hops.push_back(w);
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Offer one word. The sender runs in bursts; between bursts drop tvalid for a
  // random gap, sometimes none. tvalid is never lowered here after the handshake,
  // so back-to-back words keep it high without a second assignment in one step.
  task automatic send_word(input logic [1:0] func, input logic [6:0] a,
                           input logic [6:0] b, input check_t chk);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {b, a, func};
    do @(posedge clk); while (!s_tready);
    burst_left--;
    if (predict_word(func, a, b, chk)) useful_words++;
  endtask

  // Hold the sender until every owed result word has arrived, then let the
  // block settle.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_hops.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write node_count and/or source_node while the block is idle. The enable
  // stays high across back-to-back writes and drops once at the end.
  task automatic set_regs(input bit put_count, input logic [6:0] count_val,
                          input bit put_src, input logic [6:0] src_val);
    wait_idle();
    if (put_count) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= REG_NODE_COUNT;
      cfg_data  <= count_val;
      @(posedge clk);
      count_reg = count_val;
    end
    if (put_src) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= REG_SOURCE;
      cfg_data  <= src_val;
      @(posedge clk);
      src_reg = src_val;
    end
    cfg_wr_en <= 1'b0;
  endtask

  // Receiver: switch between stall patterns at random intervals, including
  // long stretches with no stall at all.
  ready_mode_t ready_mode = RDY_ALWAYS;
  int          ready_left = 0;
  int          ready_tick = 0;

  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 3));
      ready_left = $urandom_range(16, 120);
    end else begin
      ready_left--;
    end
    ready_tick++;
    case (ready_mode)
      RDY_ALWAYS:       m_tready <= 1'b1;
      RDY_COIN:         m_tready <= 1'($urandom_range(0, 1));
      RDY_EVERY_FOURTH: m_tready <= (ready_tick % 4 == 0);
      default:          m_tready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Check every accepted result word against the oldest owed one.
  always @(posedge clk) begin : watch_results
    hop_word_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.node    = m_tdata[6:0];
      got.hops    = m_tdata[12:7];
      got.unreach = m_tuser;
      got.last    = m_tlast;
      if (expected_hops.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result word with nothing owed: node %0d hops %0d unr %0b last %0b",
                   $realtime, got.node, got.hops, got.unreach, got.last);
      end else begin
        want = expected_hops.pop_front();
        if (got.node != want.node || got.hops != want.hops ||
            got.unreach != want.unreach || got.last != want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: mismatch: want node %0d hops %0d unr %0b last %0b,",
                     $realtime, want.node, want.hops, want.unreach, want.last,
                     " got node %0d hops %0d unr %0b last %0b",
                     got.node, got.hops, got.unreach, got.last);
        end
      end
    end
  end

  // Directed plan: corners of the fields, every function code, each special case.
  localparam int PLAN_LEN = 31;
  step_t plan [0:PLAN_LEN-1];

  initial begin : stimulus
    int         goal, edges, wide_phases, n, r, k, j, tmp;
    int         order [0:MAX_NODES-1];
    bit         big;
    logic [6:0] count_raw, src_raw, a, b;

    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    cfg_wr_en <= 1'b0;
    cfg_index <= REG_NODE_COUNT;
    cfg_data  <= '0;

    plan = '{
      // fresh from reset: 64 nodes, source 1, no edges
      '{ROW_WORD,       7'd0,   FUNC_COMPUTE, 7'd0,   7'd0,   CHK_SOURCE_ONLY},
      '{ROW_WORD,       7'd0,   FUNC_ADD,     7'd64,  7'd63,  CHK_MODEL},
      '{ROW_WORD,       7'd0,   FUNC_ADD,     7'd1,   7'd64,  CHK_MODEL},
      // self-loop, zero end, end far above n, unused function: all dropped
      '{ROW_WORD,       7'd0,   FUNC_ADD,     7'd5,   7'd5,   CHK_MODEL},
      '{ROW_WORD,       7'd0,   FUNC_ADD,     7'd0,   7'd3,   CHK_MODEL},
      '{ROW_WORD,       7'd0,   FUNC_ADD,     7'd127, 7'd1,   CHK_MODEL},
      '{ROW_WORD,       7'd0,   FUNC_SPARE,   7'd127, 7'd127, CHK_MODEL},
      '{ROW_WORD,       7'd0,   FUNC_COMPUTE, 7'd0,   7'd0,   CHK_MODEL},
      // source zero reaches nothing
      '{ROW_SET_SOURCE, 7'd0,   FUNC_ADD,     7'd0,   7'd0,   CHK_MODEL},
      '{ROW_WORD,       7'd0,   FUNC_COMPUTE, 7'd0,   7'd0,   CHK_NONE_REACHED},
      // node count zero saturates to two; old edges lie outside
      '{ROW_SET_COUNT,  7'd0,   FUNC_ADD,     7'd0,   7'd0,   CHK_MODEL},
      '{ROW_SET_SOURCE, 7'd2,   FUNC_ADD,     7'd0,   7'd0,   CHK_MODEL},
      '{ROW_WORD,       7'd0,   FUNC_COMPUTE, 7'd0,   7'd0,   CHK_SOURCE_ONLY},
      '{ROW_WORD,       7'd0,   FUNC_ADD,     7'd2,   7'd1,   CHK_MODEL},
      '{ROW_WORD,       7'd0,   FUNC_ADD,     7'd1,   7'd3,   CHK_MODEL},
      '{ROW_WORD,       7'd0,   FUNC_COMPUTE, 7'd0,   7'd0,   CHK_PAIR},
      // node count 127 saturates to 64; source at the top node
      '{ROW_SET_COUNT,  7'd127, FUNC_ADD,     7'd0,   7'd0,   CHK_MODEL},
      '{ROW_SET_SOURCE, 7'd64,  FUNC_ADD,     7'd0,   7'd0,   CHK_MODEL},
      '{ROW_WORD,       7'd0,   FUNC_COMPUTE, 7'd0,   7'd0,   CHK_MODEL},
      // source above n reaches nothing
      '{ROW_SET_SOURCE, 7'd65,  FUNC_ADD,     7'd0,   7'd0,   CHK_MODEL},
      '{ROW_WORD,       7'd0,   FUNC_COMPUTE, 7'd0,   7'd0,   CHK_NONE_REACHED},
      // clear empties the graph
      '{ROW_WORD,       7'd0,   FUNC_CLEAR,   7'd127, 7'd127, CHK_MODEL},
      '{ROW_SET_SOURCE, 7'd1,   FUNC_ADD,     7'd0,   7'd0,   CHK_MODEL},
      '{ROW_WORD,       7'd0,   FUNC_COMPUTE, 7'd0,   7'd0,   CHK_SOURCE_ONLY},
      // three-node chain measured from its far end
      '{ROW_SET_COUNT,  7'd3,   FUNC_ADD,     7'd0,   7'd0,   CHK_MODEL},
      '{ROW_SET_SOURCE, 7'd3,   FUNC_ADD,     7'd0,   7'd0,   CHK_MODEL},
      '{ROW_WORD,       7'd0,   FUNC_ADD,     7'd1,   7'd2,   CHK_MODEL},
      '{ROW_WORD,       7'd0,   FUNC_ADD,     7'd3,   7'd2,   CHK_MODEL},
      '{ROW_WORD,       7'd0,   FUNC_COMPUTE, 7'd0,   7'd0,   CHK_MODEL},
      // node count one saturates to two, leaving source 3 out of range
      '{ROW_SET_COUNT,  7'd1,   FUNC_ADD,     7'd0,   7'd0,   CHK_MODEL},
      '{ROW_WORD,       7'd0,   FUNC_COMPUTE, 7'd0,   7'd0,   CHK_NONE_REACHED}
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_SET_COUNT:  set_regs(1'b1, plan[i].value, 1'b0, 7'd0);
        ROW_SET_SOURCE: set_regs(1'b0, 7'd0, 1'b1, plan[i].value);
        default:        send_word(plan[i].func, plan[i].a, plan[i].b, plan[i].chk);
      endcase
    end

    goal = useful_words + RANDOM_WORDS;

    // One Hamiltonian path over all 64 nodes from a random source: pushes the
    // hop count to its top value of 63.
    src_raw = 7'($urandom_range(1, MAX_NODES));
    set_regs(1'b1, 7'(MAX_NODES), 1'b1, src_raw);
    send_word(FUNC_CLEAR, 7'($urandom), 7'($urandom), CHK_MODEL);
    for (k = 0; k < MAX_NODES; k++) order[k] = k + 1;
    order[src_raw - 1] = 1;
    order[0] = src_raw;
    for (k = 1; k < MAX_NODES - 1; k++) begin
      j = $urandom_range(k, MAX_NODES - 1);
      tmp = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    for (k = 1; k < MAX_NODES; k++) begin
      if ($urandom_range(0, 1))
        send_word(FUNC_ADD, 7'(order[k-1]), 7'(order[k]), CHK_MODEL);
      else
        send_word(FUNC_ADD, 7'(order[k]), 7'(order[k-1]), CHK_MODEL);
    end
    send_word(FUNC_COMPUTE, 7'($urandom), 7'($urandom), CHK_MODEL);

    // Random graphs: mostly small node counts so searches stay short, a few at
    // the full 64. Each phase reprograms both registers, maybe clears, loads
    // edges with some noise mixed in, and searches once or more.
    wide_phases = 0;
    while (useful_words < goal) begin
      big = (wide_phases < MAX_WIDE) && ($urandom_range(0, 11) == 0);
      if (big) begin
        count_raw = $urandom_range(0, 1) ? 7'(MAX_NODES) : 7'($urandom_range(65, 127));
        wide_phases++;
      end else if ($urandom_range(0, 9) == 0) begin
        count_raw = 7'($urandom_range(0, 1));
      end else begin
        count_raw = 7'($urandom_range(2, 12));
      end
      n = active_count(count_raw);
      r = $urandom_range(0, 9);
      if (r == 0)      src_raw = 7'd0;
      else if (r == 1) src_raw = 7'($urandom_range(n + 1, 127));
      else             src_raw = 7'($urandom_range(1, n));
      set_regs(1'b1, count_raw, 1'b1, src_raw);

      if ($urandom_range(0, 2) == 0)
        send_word(FUNC_CLEAR, 7'($urandom), 7'($urandom), CHK_MODEL);

      edges = big ? $urandom_range(30, 90) : $urandom_range(0, 2 * n);
      for (k = 0; k < edges; k++) begin
        r = $urandom_range(0, 9);
        if (r == 0) begin
          // noise: any function code, any field bits
          send_word(2'($urandom_range(0, 3)), 7'($urandom), 7'($urandom), CHK_MODEL);
        end else if (r == 1) begin
          a = 7'($urandom_range(1, n));
          send_word(FUNC_ADD, a, a, CHK_MODEL);
        end else begin
          a = 7'($urandom_range(1, n));
          b = 7'($urandom_range(1, n - 1));
          if (b >= a) b++;
          send_word(FUNC_ADD, a, b, CHK_MODEL);
        end
        if (!big && $urandom_range(0, 5) == 0)
          send_word(FUNC_COMPUTE, 7'($urandom), 7'($urandom), CHK_MODEL);
      end
      send_word(FUNC_COMPUTE, 7'($urandom), 7'($urandom), CHK_MODEL);
    end

    wait_idle();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Hard stop in case the block hangs or stops answering.
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("== FAIL ==");
    $finish;
  end

endmodule

### files.f
design/usp_pkg.sv
design/usp_adj_mem.sv
design/unit_weight_shortest_path.sv
tb/tb.sv
